[sv/assert_macros.svh]
// Assertion macros shared by the timing wheel event store RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: condition does not hold");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication does not hold");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication does not hold");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[sv/tws_pkg.sv]
// Shared types and constants of the timing wheel event store.
`timescale 1ns / 1ps
package tws_pkg;
   localparam int POOL_DEPTH_DEF = 512;
   localparam int SLOT_COUNT_DEF = 128;

   localparam int TS_W        = 16;
   localparam int BYTE_W      = 8;
   localparam int PARAM_W     = 16;
   localparam int IDX_OUT_W   = 9;
   localparam int MODE_W      = 2;
   localparam int PAYLOAD_W   = 2 * BYTE_W + 2 * PARAM_W;
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 72;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_LOOKUP = 2'd1,
      MODE_READ   = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC,
      ST_LOOK,
      ST_FIN
   } state_type;
endpackage

[sv/tws_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module tws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[sv/tws_slot_calc.sv]
// Wheel slot of a time stamp: time stamp modulo the slot count over two stages.
`timescale 1ns / 1ps
module tws_slot_calc #(
   parameter int SLOT_COUNT = tws_pkg::SLOT_COUNT_DEF
) (
   input  logic                          clock,
   input  logic [tws_pkg::TS_W-1:0]      time_stamp,
   output logic [$clog2(SLOT_COUNT)-1:0] slot
);
   import tws_pkg::*;

   localparam int SW = $clog2(SLOT_COUNT);
   // Rounded-up reciprocal; exact quotient for every 16-bit time stamp.
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / SLOT_COUNT + 1);

   logic [TS_W-1:0] quot_ff;
   logic [TS_W-1:0] quot_in;
   logic [47:0]     prod;
   logic [31:0]     quot_mul;
   logic [31:0]     rem;

   assign prod    = 48'(time_stamp) * 48'(RECIP);
   assign quot_in = prod[47:32];

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign quot_mul = 32'(quot_ff) * 32'(SLOT_COUNT);
   assign rem      = 32'(time_stamp) - quot_mul;
   assign slot     = rem[SW-1:0];
endmodule

[sv/timing_wheel_event_store_top.sv]
// Insert, lookup and read pass the CALC, LOOK and FIN states after acceptance; FIN registers
// the result item and waits while a held response is not taken. A new request is taken only in IDLE.
// Clear all sweeps every slot of the slot table, then gives its response from FIN.
// Reset is synchronous, active high; afterwards a sweep over every slot clears
// the slot table while req_tready stays low.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module timing_wheel_event_store_top #(
   parameter int POOL_DEPTH = tws_pkg::POOL_DEPTH_DEF,
   parameter int SLOT_COUNT = tws_pkg::SLOT_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // time_stamp[15:0], instrument[23:16], event_type[31:24], param_a[47:32],
   // param_b[63:48], entry_index[72:64], zero fill above
   input  logic [tws_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // mode[1:0]
   input  logic [tws_pkg::MODE_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // accepted[0], found[1], result_index[10:2], out_instrument[18:11],
   // out_type[26:19], out_param_a[42:27], out_param_b[58:43], has_next[59],
   // next_index[68:60], zero fill above
   output logic [tws_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import tws_pkg::*;

   localparam int PW     = $clog2(POOL_DEPTH);
   localparam int SW     = $clog2(SLOT_COUNT);
   localparam int CW     = $clog2(POOL_DEPTH + 1);
   localparam int SLOT_W = 2 * PW + 1;
   localparam int LINK_W = PW + 1;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [SW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic                 clr_rsp_ff, clr_rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   mode_type             req_mode_ff;
   logic [TS_W-1:0]      req_ts_ff;
   logic [PAYLOAD_W-1:0] req_payload_ff;
   logic [IDX_OUT_W-1:0] req_idx_ff;

   logic                 req_fire;
   logic                 fin_fire;
   logic                 clr_last;
   logic                 ins_ok;
   logic                 rd_used;
   logic [PW-1:0]        new_entry;
   logic [SW-1:0]        slot;

   logic                 slot_wr_en, slot_rd_en;
   logic [SW-1:0]        slot_wr_addr;
   logic [SLOT_W-1:0]    slot_wr_data, slot_rd_data;
   logic                 slot_valid;
   logic [PW-1:0]        slot_head, slot_tail;

   logic                 pay_wr_en, ent_rd_en;
   logic [PW-1:0]        ent_rd_addr;
   logic [PAYLOAD_W-1:0] pay_rd_data;
   logic                 link_wr_en;
   logic [PW-1:0]        link_wr_addr;
   logic [LINK_W-1:0]    link_wr_data, link_rd_data;

   logic                 accepted;
   logic                 found;
   logic [IDX_OUT_W-1:0] result_index;
   logic [PAYLOAD_W-1:0] out_payload;
   logic                 has_next;
   logic [IDX_OUT_W-1:0] next_index;

   assign req_fire  = req_tvalid && req_tready;
   assign fin_fire  = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_tready);
   assign clr_last  = (clr_cnt_ff == SW'(SLOT_COUNT - 1));
   assign ins_ok    = (count_ff != CW'(POOL_DEPTH));
   assign new_entry = PW'(count_ff);
   // Entries are freed only by clear all, so exactly those below the fill count are in use.
   assign rd_used   = (32'(req_idx_ff) < 32'(count_ff));

   assign slot_valid = slot_rd_data[SLOT_W-1];
   assign slot_head  = slot_rd_data[2*PW-1:PW];
   assign slot_tail  = slot_rd_data[PW-1:0];

   tws_slot_calc #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_slot_calc (
      .clock     (clock),
      .time_stamp(req_ts_ff),
      .slot      (slot)
   );

   // Per slot: valid, head entry, tail entry.
   tws_ram #(
      .WIDTH(SLOT_W),
      .DEPTH(SLOT_COUNT)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (slot_wr_en),
      .wr_addr(slot_wr_addr),
      .wr_data(slot_wr_data),
      .rd_en  (slot_rd_en),
      .rd_addr(slot),
      .rd_data(slot_rd_data)
   );

   tws_ram #(
      .WIDTH(PAYLOAD_W),
      .DEPTH(POOL_DEPTH)
   ) u_payload_ram (
      .clock  (clock),
      .wr_en  (pay_wr_en),
      .wr_addr(new_entry),
      .wr_data(req_payload_ff),
      .rd_en  (ent_rd_en),
      .rd_addr(ent_rd_addr),
      .rd_data(pay_rd_data)
   );

   // Per entry: link valid, next entry.
   tws_ram #(
      .WIDTH(LINK_W),
      .DEPTH(POOL_DEPTH)
   ) u_link_ram (
      .clock  (clock),
      .wr_en  (link_wr_en),
      .wr_addr(link_wr_addr),
      .wr_data(link_wr_data),
      .rd_en  (ent_rd_en),
      .rd_addr(ent_rd_addr),
      .rd_data(link_rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = clr_rsp_ff ? ST_FIN : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (mode_type'(req_tuser) == MODE_CLEAR) ? ST_CLEAR : ST_CALC;
            end
         end
         ST_CALC: state_in = ST_LOOK;
         ST_LOOK: state_in = ST_FIN;
         ST_FIN: begin
            if (fin_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Memory controls and result fields.
   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      slot_wr_en   = 1'b0;
      slot_wr_addr = slot;
      slot_wr_data = '0;
      slot_rd_en   = 1'b0;
      pay_wr_en    = 1'b0;
      ent_rd_en    = 1'b0;
      ent_rd_addr  = PW'(req_idx_ff);
      link_wr_en   = 1'b0;
      link_wr_addr = new_entry;
      link_wr_data = '0;
      accepted     = 1'b1;
      found        = 1'b0;
      result_index = '0;
      out_payload  = '0;
      has_next     = 1'b0;
      next_index   = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            slot_wr_en   = 1'b1;
            slot_wr_addr = clr_cnt_ff;
         end
         ST_LOOK: begin
            slot_rd_en = (req_mode_ff == MODE_INSERT) || (req_mode_ff == MODE_LOOKUP);
            ent_rd_en  = (req_mode_ff == MODE_READ);
            if ((req_mode_ff == MODE_INSERT) && ins_ok) begin
               pay_wr_en  = 1'b1;
               link_wr_en = 1'b1;
            end
         end
         ST_FIN: begin
            unique case (req_mode_ff)
               MODE_INSERT: begin
                  accepted = ins_ok;
                  if (ins_ok) begin
                     result_index = IDX_OUT_W'(new_entry);
                     slot_wr_en   = fin_fire;
                     if (slot_valid) begin
                        // Append behind the current tail.
                        link_wr_en   = fin_fire;
                        link_wr_addr = slot_tail;
                        link_wr_data = {1'b1, new_entry};
                        slot_wr_data = {1'b1, slot_head, new_entry};
                     end else begin
                        slot_wr_data = {1'b1, new_entry, new_entry};
                     end
                  end
               end
               MODE_LOOKUP: begin
                  found = slot_valid;
                  if (slot_valid) begin
                     result_index = IDX_OUT_W'(slot_head);
                  end
               end
               MODE_READ: begin
                  found = rd_used;
                  if (rd_used) begin
                     out_payload = pay_rd_data;
                     has_next    = link_rd_data[LINK_W-1];
                     if (link_rd_data[LINK_W-1]) begin
                        next_index = IDX_OUT_W'(link_rd_data[PW-1:0]);
                     end
                  end
               end
               MODE_CLEAR: begin
                  accepted = 1'b1;
               end
               default: accepted = 1'b1;
            endcase
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == ST_CLEAR) begin
         clr_cnt_in = clr_last ? '0 : clr_cnt_ff + 1'b1;
      end
      if (req_fire && (mode_type'(req_tuser) == MODE_CLEAR)) begin
         clr_rsp_in = 1'b1;
         count_in   = '0;
      end
      if (fin_fire) begin
         rsp_valid_in = 1'b1;
         clr_rsp_in   = 1'b0;
         rsp_data_in  = RSP_TDATA_W'({next_index, has_next, out_payload,
                                      result_index, found, accepted});
         if ((req_mode_ff == MODE_INSERT) && ins_ok) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         count_ff     <= '0;
         clr_cnt_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (req_fire) begin
         req_mode_ff    <= mode_type'(req_tuser);
         req_ts_ff      <= req_tdata[15:0];
         req_payload_ff <= req_tdata[63:16];
         req_idx_ff     <= req_tdata[72:64];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, 32'(count_ff) <= 32'(POOL_DEPTH))
   `ASSERT_NEXT(a_count_step, clock, reset, fin_fire && (req_mode_ff == MODE_INSERT) && ins_ok, count_ff == CW'($past(count_ff) + 1'b1))
   `ASSERT_IMPLIES(a_no_accept_in_sweep, clock, reset, state_ff == ST_CLEAR, !req_tready && !slot_rd_en)
endmodule
